// File: hdl/vdolly_pkg.sv
// ---------------------------------------------------------------------------
// vdolly_pkg
// Shared types and constants for the view point dolly step pipeline.
// ---------------------------------------------------------------------------
package vdolly_pkg;

  localparam int COORD_W  = 32;             // Q19.12 coordinate
  localparam int DELTA_W  = COORD_W + 1;    // exact target - eye
  localparam int RAD_W    = 64;             // sum of two squares
  localparam int ROOT_W   = RAD_W / 2;
  localparam int LEAD_D_W = ROOT_W;         // lead divide: divisor is the root
  localparam int LEAD_Q_W = 32;
  localparam int FOL_D_W  = DELTA_W;        // follower divide: divisor is |lead delta|
  localparam int FOL_Q_W  = 35;
  localparam int MOVE_W   = 36;             // signed move, holds +/- 2^34
  localparam logic [MOVE_W-1:0] FOL_CLAMP = MOVE_W'(64'h4_0000_0000);

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] tgt_x;
    logic signed [COORD_W-1:0] tgt_y;
    logic signed [COORD_W-1:0] tgt_z;
    logic                      both;
    logic                      moved;
    axis_t                     lead;
    logic                      use_step;
    logic signed [COORD_W-1:0] step;
    logic signed [DELTA_W-1:0] da;    // lead delta
    logic signed [DELTA_W-1:0] df0;   // lower follower delta
    logic signed [DELTA_W-1:0] df1;   // upper follower delta
  } base_t;

  typedef struct packed {
    base_t       b;
    logic [62:0] prod;   // |step| * |a|
  } sq_side_t;

  typedef struct packed {
    base_t b;
    logic  rz;           // root was zero
  } lead_side_t;

  typedef struct packed {
    base_t                     b;
    logic signed [DELTA_W-1:0] m;
    logic                      sf0;
    logic                      sf1;
    logic                      ovf0;
  } fol_side_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] tgt_x;
    logic signed [COORD_W-1:0] tgt_y;
    logic signed [COORD_W-1:0] tgt_z;
    logic                      moved;
  } result_t;

endpackage

// File: hdl/vdolly_sqrt.sv
// ---------------------------------------------------------------------------
// vdolly_sqrt
// Pipelined integer square root, one root bit per stage, with a side payload.
// ---------------------------------------------------------------------------
module vdolly_sqrt #(
  parameter int SW = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [vdolly_pkg::RAD_W-1:0]  in_rad,
  input  logic [SW-1:0]                 in_side,
  output logic                          out_vld,
  output logic [vdolly_pkg::ROOT_W-1:0] out_root,
  output logic [SW-1:0]                 out_side
);
  import vdolly_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] q_r    [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [SW-1:0]     side_r [ROOT_W];
  logic              v_r    [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] q_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SW-1:0]     side_in;
    logic              v_in;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign q_in    = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
      assign v_in    = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign q_in    = q_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign side_in = side_r[g-1];
      assign v_in    = v_r[g-1];
    end

    // bring down two radicand bits, try (2q << 1) | 1
    always_comb begin
      t     = {rem_in, rad_in[RAD_W-1 -: 2]};
      trial = {2'b00, q_in, 2'b01};
      diff  = t - trial;
      ge    = (t >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        q_r[g]    <= {q_in[ROOT_W-2:0], ge};
        rad_r[g]  <= {rad_in[RAD_W-3:0], 2'b00};
        side_r[g] <= side_in;
      end
    end
  end

  assign out_vld  = v_r[ROOT_W-1];
  assign out_root = q_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// File: hdl/vdolly_div.sv
// ---------------------------------------------------------------------------
// vdolly_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// The starting remainder must be below the divisor.
// ---------------------------------------------------------------------------
module vdolly_div #(
  parameter int DW = vdolly_pkg::LEAD_D_W,
  parameter int QW = vdolly_pkg::LEAD_Q_W,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_q,
  output logic [SW-1:0] out_side
);
  import vdolly_pkg::*;

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] num_r  [QW];
  logic [DW-1:0] div_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [SW-1:0] side_r [QW];
  logic          v_r    [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] num_in;
    logic [DW-1:0] div_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] side_in;
    logic          v_in;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_in  = in_rem;
      assign num_in  = in_num;
      assign div_in  = in_div;
      assign q_in    = '0;
      assign side_in = in_side;
      assign v_in    = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign num_in  = num_r[g-1];
      assign div_in  = div_r[g-1];
      assign q_in    = q_r[g-1];
      assign side_in = side_r[g-1];
      assign v_in    = v_r[g-1];
    end

    always_comb begin
      t    = {rem_in, num_in[QW-1]};
      diff = t - {1'b0, div_in};
      ge   = (t >= {1'b0, div_in});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        num_r[g]  <= {num_in[QW-2:0], 1'b0};
        div_r[g]  <= div_in;
        q_r[g]    <= {q_in[QW-2:0], ge};
        side_r[g] <= side_in;
      end
    end
  end

  assign out_vld  = v_r[QW-1];
  assign out_q    = q_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

// File: hdl/view_point_dolly_step.sv
// Pipeline from input transfer to out_valid: 3 setup stages, 32-stage
// square root, 32-stage lead divide, 4 move stages, 35-stage follower divide,
// 2 sum stages, output register.
// Throughput: one item per cycle while skid is empty; all stages register under one enable.
// A two-entry output buffer (output register plus skid) keeps input open while a result waits.
// Reset: synchronous active-low rst_n clears all valid bits and the output buffer.
// ---------------------------------------------------------------------------
// view_point_dolly_step
// Moves an eye point (and optionally the target) along the eye-target line
// by a signed step, Q19.12 fixed point with saturation.
// ---------------------------------------------------------------------------
module view_point_dolly_step (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_eye_x,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_eye_y,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_eye_z,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_target_z,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_step,
  input  logic                                in_move_both,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vdolly_pkg::COORD_W-1:0] out_new_eye_x,
  output logic signed [vdolly_pkg::COORD_W-1:0] out_new_eye_y,
  output logic signed [vdolly_pkg::COORD_W-1:0] out_new_eye_z,
  output logic signed [vdolly_pkg::COORD_W-1:0] out_new_target_x,
  output logic signed [vdolly_pkg::COORD_W-1:0] out_new_target_y,
  output logic signed [vdolly_pkg::COORD_W-1:0] out_new_target_z,
  output logic                                out_moved
);
  import vdolly_pkg::*;

  function automatic logic [DELTA_W-1:0] mag33(input logic signed [DELTA_W-1:0] v);
    mag33 = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [MOVE_W:0] v);
    logic signed [MOVE_W:0] hi;
    logic signed [MOVE_W:0] lo;
    hi = (MOVE_W+1)'(64'sd2147483647);
    lo = -(MOVE_W+1)'(64'sd2147483648);
    if (v > hi) sat32 = COORD_W'(hi);
    else if (v < lo) sat32 = COORD_W'(lo);
    else sat32 = COORD_W'(v);
  endfunction

  logic en;
  logic sk_v_r;
  assign en       = !sk_v_r;
  assign in_ready = en;

  // ---------------- stage 1: deltas and axis choice ----------------
  logic signed [DELTA_W-1:0] dx, dy, dz;
  base_t                     s1_b_nxt;
  logic signed [DELTA_W-1:0] s1_db_nxt;
  base_t                     s1_b_r;
  logic signed [DELTA_W-1:0] s1_db_r;
  logic                      s1_v_r;

  always_comb begin
    dx = DELTA_W'(in_target_x) - DELTA_W'(in_eye_x);
    dy = DELTA_W'(in_target_y) - DELTA_W'(in_eye_y);
    dz = DELTA_W'(in_target_z) - DELTA_W'(in_eye_z);
    s1_b_nxt.eye_x = in_eye_x;
    s1_b_nxt.eye_y = in_eye_y;
    s1_b_nxt.eye_z = in_eye_z;
    s1_b_nxt.tgt_x = in_target_x;
    s1_b_nxt.tgt_y = in_target_y;
    s1_b_nxt.tgt_z = in_target_z;
    s1_b_nxt.both  = in_move_both;
    s1_b_nxt.step  = in_step;
    s1_b_nxt.moved = !((dx == '0 && dy == '0 && dz == '0) || in_step == '0);
    // followers are the two non-lead axes in x, y, z order
    if (dy == '0 && dx == '0) begin
      s1_b_nxt.lead = AXIS_Z; s1_b_nxt.use_step = 1'b1;
      s1_b_nxt.da = dz; s1_db_nxt = '0; s1_b_nxt.df0 = dx; s1_b_nxt.df1 = dy;
    end else if (dy == '0) begin
      s1_b_nxt.lead = AXIS_X; s1_b_nxt.use_step = 1'b0;
      s1_b_nxt.da = dx; s1_db_nxt = dz; s1_b_nxt.df0 = dy; s1_b_nxt.df1 = dz;
    end else if (dx == '0 && dz == '0) begin
      s1_b_nxt.lead = AXIS_Y; s1_b_nxt.use_step = 1'b1;
      s1_b_nxt.da = dy; s1_db_nxt = '0; s1_b_nxt.df0 = dx; s1_b_nxt.df1 = dz;
    end else if (dx == '0) begin
      s1_b_nxt.lead = AXIS_Z; s1_b_nxt.use_step = 1'b0;
      s1_b_nxt.da = dz; s1_db_nxt = dy; s1_b_nxt.df0 = dx; s1_b_nxt.df1 = dy;
    end else begin
      s1_b_nxt.lead = AXIS_X; s1_b_nxt.use_step = 1'b0;
      s1_b_nxt.da = dx; s1_db_nxt = dy; s1_b_nxt.df0 = dy; s1_b_nxt.df1 = dz;
    end
  end

  // ---------------- stage 2: squares and |step|*|a| ----------------
  logic [DELTA_W-1:0] ua, ub;
  logic               shr;
  logic [31:0]        ua_s, ub_s, stepm;
  logic [63:0]        prod_full;
  base_t              s2_b_r;
  logic [63:0]        s2_sqa_r, s2_sqb_r;
  logic [62:0]        s2_prod_r;
  logic               s2_v_r;

  always_comb begin
    ua    = mag33(s1_b_r.da);
    ub    = mag33(s1_db_r);
    shr   = ua[32] | ua[31] | ub[32] | ub[31];
    ua_s  = shr ? ua[32:1] : ua[31:0];
    ub_s  = shr ? ub[32:1] : ub[31:0];
    stepm = s1_b_r.step[31] ? 32'(-s1_b_r.step) : 32'(s1_b_r.step);
    prod_full = 64'(stepm) * 64'(ua_s);
  end

  // ---------------- stage 3: radicand ----------------
  base_t       s3_b_r;
  logic [63:0] s3_rad_r;
  logic [62:0] s3_prod_r;
  logic        s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_b_r    <= s1_b_nxt;
      s1_db_r   <= s1_db_nxt;
      s2_b_r    <= s1_b_r;
      s2_sqa_r  <= 64'(ua_s) * 64'(ua_s);
      s2_sqb_r  <= 64'(ub_s) * 64'(ub_s);
      s2_prod_r <= prod_full[62:0];
      s3_b_r    <= s2_b_r;
      s3_rad_r  <= s2_sqa_r + s2_sqb_r;
      s3_prod_r <= s2_prod_r;
    end
  end

  // ---------------- square root ----------------
  sq_side_t           sq_in_side, sq_out_side;
  logic               sq_out_vld;
  logic [ROOT_W-1:0]  sq_root;

  assign sq_in_side.b    = s3_b_r;
  assign sq_in_side.prod = s3_prod_r;

  vdolly_sqrt #(
    .SW($bits(sq_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_v_r),
    .in_rad   (s3_rad_r),
    .in_side  (sq_in_side),
    .out_vld  (sq_out_vld),
    .out_root (sq_root),
    .out_side (sq_out_side)
  );

  // ---------------- lead divide: |step|*|a| / r ----------------
  lead_side_t           ld_in_side, ld_out_side;
  logic                 ld_out_vld;
  logic [LEAD_Q_W-1:0]  ld_q;

  assign ld_in_side.b  = sq_out_side.b;
  assign ld_in_side.rz = (sq_root == '0);

  vdolly_div #(
    .DW(LEAD_D_W),
    .QW(LEAD_Q_W),
    .SW($bits(lead_side_t))
  ) u_div_lead (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_out_vld),
    .in_rem   ({1'b0, sq_out_side.prod[62:32]}),
    .in_num   (sq_out_side.prod[31:0]),
    .in_div   (sq_root),
    .in_side  (ld_in_side),
    .out_vld  (ld_out_vld),
    .out_q    (ld_q),
    .out_side (ld_out_side)
  );

  // ---------------- stage 4: signed lead move ----------------
  logic signed [DELTA_W-1:0] m0_nxt, mag_q;
  base_t                     s4_b_r;
  logic signed [DELTA_W-1:0] s4_m0_r;
  logic                      s4_v_r;

  always_comb begin
    mag_q = DELTA_W'({1'b0, ld_q});
    if (ld_out_side.b.use_step) begin
      m0_nxt = DELTA_W'(ld_out_side.b.step);
    end else if (ld_out_side.rz) begin
      m0_nxt = '0;
    end else if (ld_out_side.b.step[COORD_W-1] != ld_out_side.b.da[DELTA_W-1]) begin
      m0_nxt = -mag_q;
    end else begin
      m0_nxt = mag_q;
    end
  end

  // ---------------- stage 5: away-or-toward test ----------------
  logic signed [DELTA_W:0]   diff5;
  logic [DELTA_W:0]          after5;
  logic [DELTA_W-1:0]        before5;
  logic                      flip5;
  base_t                     s5_b_r;
  logic signed [DELTA_W-1:0] s5_m_r;
  logic                      s5_v_r;

  always_comb begin
    diff5   = (DELTA_W+1)'(s4_b_r.da) - (DELTA_W+1)'(s4_m0_r);
    after5  = diff5[DELTA_W] ? (DELTA_W+1)'(-diff5) : (DELTA_W+1)'(diff5);
    before5 = mag33(s4_b_r.da);
    flip5   = (!s4_b_r.step[COORD_W-1] && s4_b_r.step != '0 &&
               after5 > (DELTA_W+1)'(before5)) ||
              (s4_b_r.step[COORD_W-1] && after5 < (DELTA_W+1)'(before5));
  end

  // ---------------- stage 6: follower products ----------------
  logic [31:0]        mm6;
  logic [DELTA_W-1:0] f0m6, f1m6, mm6_full;
  base_t              s6_b_r;
  logic signed [DELTA_W-1:0] s6_m_r;
  logic [63:0]        s6_p0_r, s6_p1_r;
  logic               s6_sf0_r, s6_sf1_r;
  logic               s6_v_r;

  always_comb begin
    mm6_full = mag33(s5_m_r);
    mm6      = mm6_full[31:0];
    f0m6     = mag33(s5_b_r.df0);
    f1m6     = mag33(s5_b_r.df1);
  end

  // ---------------- stage 7: follower overflow check ----------------
  base_t              s7_b_r;
  logic signed [DELTA_W-1:0] s7_m_r;
  logic [63:0]        s7_p0_r, s7_p1_r;
  logic [DELTA_W-1:0] s7_ua_r;
  logic [DELTA_W-1:0] s6_ua_r;
  logic               s7_sf0_r, s7_sf1_r, s7_ovf0_r, s7_ovf1_r;
  logic               s7_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= ld_out_vld;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_b_r    <= ld_out_side.b;
      s4_m0_r   <= m0_nxt;
      s5_b_r    <= s4_b_r;
      s5_m_r    <= flip5 ? -s4_m0_r : s4_m0_r;
      s6_b_r    <= s5_b_r;
      s6_m_r    <= s5_m_r;
      s6_p0_r   <= 64'(f0m6) * 64'(mm6);
      s6_p1_r   <= 64'(f1m6) * 64'(mm6);
      s6_sf0_r  <= s5_b_r.df0[DELTA_W-1] ^ s5_m_r[DELTA_W-1];
      s6_sf1_r  <= s5_b_r.df1[DELTA_W-1] ^ s5_m_r[DELTA_W-1];
      s6_ua_r   <= mag33(s5_b_r.da);
      s7_b_r    <= s6_b_r;
      s7_m_r    <= s6_m_r;
      s7_p0_r   <= s6_p0_r;
      s7_p1_r   <= s6_p1_r;
      s7_ua_r   <= s6_ua_r;
      s7_sf0_r  <= s6_sf0_r;
      s7_sf1_r  <= s6_sf1_r;
      // quotient would need more than FOL_Q_W bits: clamp anyway
      s7_ovf0_r <= (DELTA_W'(s6_p0_r[63:FOL_Q_W]) >= s6_ua_r);
      s7_ovf1_r <= (DELTA_W'(s6_p1_r[63:FOL_Q_W]) >= s6_ua_r);
    end
  end

  // ---------------- follower divides ----------------
  fol_side_t           f_in_side, f_out_side;
  logic                f_out_vld;
  logic [FOL_Q_W-1:0]  f0_q, f1_q;
  logic                f1_ovf;

  assign f_in_side.b    = s7_b_r;
  assign f_in_side.m    = s7_m_r;
  assign f_in_side.sf0  = s7_sf0_r;
  assign f_in_side.sf1  = s7_sf1_r;
  assign f_in_side.ovf0 = s7_ovf0_r;

  vdolly_div #(
    .DW(FOL_D_W),
    .QW(FOL_Q_W),
    .SW($bits(fol_side_t))
  ) u_div_f0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s7_v_r),
    .in_rem   (s7_ovf0_r ? '0 : FOL_D_W'(s7_p0_r[63:FOL_Q_W])),
    .in_num   (s7_p0_r[FOL_Q_W-1:0]),
    .in_div   (s7_ua_r),
    .in_side  (f_in_side),
    .out_vld  (f_out_vld),
    .out_q    (f0_q),
    .out_side (f_out_side)
  );

  vdolly_div #(
    .DW(FOL_D_W),
    .QW(FOL_Q_W),
    .SW(1)
  ) u_div_f1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s7_v_r),
    .in_rem   (s7_ovf1_r ? '0 : FOL_D_W'(s7_p1_r[63:FOL_Q_W])),
    .in_num   (s7_p1_r[FOL_Q_W-1:0]),
    .in_div   (s7_ua_r),
    .in_side  (s7_ovf1_r),
    .out_vld  (),
    .out_q    (f1_q),
    .out_side (f1_ovf)
  );

  // ---------------- stage 8: per-axis moves ----------------
  logic [MOVE_W-1:0]        fm0, fm1;
  logic signed [MOVE_W-1:0] mvf0, mvf1, mvl;
  logic signed [MOVE_W-1:0] mvx_nxt, mvy_nxt, mvz_nxt;
  base_t                    s8_b_r;
  logic signed [MOVE_W-1:0] s8_mvx_r, s8_mvy_r, s8_mvz_r;
  logic                     s8_v_r;

  always_comb begin
    fm0 = (f_out_side.ovf0 || MOVE_W'(f0_q) > FOL_CLAMP) ? FOL_CLAMP : MOVE_W'(f0_q);
    fm1 = (f1_ovf || MOVE_W'(f1_q) > FOL_CLAMP) ? FOL_CLAMP : MOVE_W'(f1_q);
    mvf0 = f_out_side.sf0 ? -$signed(fm0) : $signed(fm0);
    mvf1 = f_out_side.sf1 ? -$signed(fm1) : $signed(fm1);
    mvl  = MOVE_W'(f_out_side.m);
    case (f_out_side.b.lead)
      AXIS_X: begin mvx_nxt = mvl;  mvy_nxt = mvf0; mvz_nxt = mvf1; end
      AXIS_Y: begin mvx_nxt = mvf0; mvy_nxt = mvl;  mvz_nxt = mvf1; end
      AXIS_Z: begin mvx_nxt = mvf0; mvy_nxt = mvf1; mvz_nxt = mvl;  end
      default: begin mvx_nxt = '0; mvy_nxt = '0; mvz_nxt = '0; end
    endcase
    if (!f_out_side.b.moved) begin
      mvx_nxt = '0;
      mvy_nxt = '0;
      mvz_nxt = '0;
    end
  end

  // ---------------- stage 9: sums and saturation ----------------
  result_t td_nxt;
  result_t td_r;
  logic    tv_r;

  always_comb begin
    td_nxt.eye_x = sat32((MOVE_W+1)'(s8_b_r.eye_x) + (MOVE_W+1)'(s8_mvx_r));
    td_nxt.eye_y = sat32((MOVE_W+1)'(s8_b_r.eye_y) + (MOVE_W+1)'(s8_mvy_r));
    td_nxt.eye_z = sat32((MOVE_W+1)'(s8_b_r.eye_z) + (MOVE_W+1)'(s8_mvz_r));
    td_nxt.tgt_x = s8_b_r.both ?
                   sat32((MOVE_W+1)'(s8_b_r.tgt_x) + (MOVE_W+1)'(s8_mvx_r)) : s8_b_r.tgt_x;
    td_nxt.tgt_y = s8_b_r.both ?
                   sat32((MOVE_W+1)'(s8_b_r.tgt_y) + (MOVE_W+1)'(s8_mvy_r)) : s8_b_r.tgt_y;
    td_nxt.tgt_z = s8_b_r.both ?
                   sat32((MOVE_W+1)'(s8_b_r.tgt_z) + (MOVE_W+1)'(s8_mvz_r)) : s8_b_r.tgt_z;
    td_nxt.moved = s8_b_r.moved;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
      tv_r   <= 1'b0;
    end else if (en) begin
      s8_v_r <= f_out_vld;
      tv_r   <= s8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_b_r   <= f_out_side.b;
      s8_mvx_r <= mvx_nxt;
      s8_mvy_r <= mvy_nxt;
      s8_mvz_r <= mvz_nxt;
      td_r     <= td_nxt;
    end
  end

  // ---------------- output register and skid ----------------
  result_t out_d_r, sk_d_r;
  logic    out_v_r;
  logic    out_v_nxt, sk_v_nxt;
  logic    take;

  assign take = out_v_r && out_ready;

  always_comb begin
    out_v_nxt = out_v_r && !take;
    sk_v_nxt  = sk_v_r;
    if (sk_v_r && take) begin
      out_v_nxt = 1'b1;
      sk_v_nxt  = 1'b0;
    end else if (en && tv_r) begin
      if (!out_v_r || take) out_v_nxt = 1'b1;
      else sk_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r && take) begin
      out_d_r <= sk_d_r;
    end else if (en && tv_r) begin
      if (!out_v_r || take) out_d_r <= td_r;
      else sk_d_r <= td_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_new_eye_x    = out_d_r.eye_x;
  assign out_new_eye_y    = out_d_r.eye_y;
  assign out_new_eye_z    = out_d_r.eye_z;
  assign out_new_target_x = out_d_r.tgt_x;
  assign out_new_target_y = out_d_r.tgt_y;
  assign out_new_target_z = out_d_r.tgt_z;
  assign out_moved        = out_d_r.moved;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid holds a result while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (sk_v_r && !out_ready) |=> (sk_v_r && $stable(sk_d_r)))
    else $error("skid entry lost or changed during stall");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready && tv_r && !sk_v_r) |=> sk_v_r)
    else $error("pipeline result dropped on output stall");
`endif

endmodule

// File: test/vdolly_checker.sv
// ---------------------------------------------------------------------------
// vdolly_checker
// Watches the request and result channels of the dolly step block, predicts
// each moved point pair from the request fields and compares in order.
// ---------------------------------------------------------------------------
module vdolly_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_eye_x,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_eye_y,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_eye_z,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_target_x,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_target_y,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_target_z,
  input  logic signed [vdolly_pkg::COORD_W-1:0] in_step,
  input  logic                                  in_move_both,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [vdolly_pkg::COORD_W-1:0] out_new_eye_x,
  input  logic signed [vdolly_pkg::COORD_W-1:0] out_new_eye_y,
  input  logic signed [vdolly_pkg::COORD_W-1:0] out_new_eye_z,
  input  logic signed [vdolly_pkg::COORD_W-1:0] out_new_target_x,
  input  logic signed [vdolly_pkg::COORD_W-1:0] out_new_target_y,
  input  logic signed [vdolly_pkg::COORD_W-1:0] out_new_target_z,
  input  logic                                  out_moved,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    moved_count
);
  import vdolly_pkg::*;

  result_t expected_moves[$];

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint orient(longint stp, longint d, longint m);
    longint unsigned after_m, before_m;
    after_m = mag(d - m);
    before_m = mag(d);
    if ((stp > 0 && after_m > before_m) || (stp < 0 && after_m < before_m)) return -m;
    return m;
  endfunction

  // step * a / hypot(a, b), then flipped if the move heads the wrong way
  function automatic longint lead_dist(longint stp, longint a, longint b);
    longint unsigned ua, ub, r, m;
    longint mv;
    ua = mag(a);
    ub = mag(b);
    if (ua >= 64'h8000_0000 || ub >= 64'h8000_0000) begin
      ua = ua >> 1;
      ub = ub >> 1;
    end
    r = int_sqrt(ua * ua + ub * ub);
    if (r == 0) mv = 0;
    else begin
      m = (mag(stp) * ua) / r;
      mv = ((stp < 0) != (a < 0)) ? -longint'(m) : longint'(m);
    end
    return orient(stp, a, mv);
  endfunction

  function automatic longint follow(longint b, longint m, longint a);
    longint unsigned q;
    if (a == 0) return 0;
    q = (mag(b) * mag(m)) / mag(a);
    if (q > 64'h4_0000_0000) q = 64'h4_0000_0000;
    return ((b < 0) != (m < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic result_t predict_dolly(longint ex, longint ey, longint ez, longint tx,
                                            longint ty, longint tz, longint stp, logic both);
    result_t r;
    longint dx, dy, dz, mx, my, mz;
    dx = tx - ex; dy = ty - ey; dz = tz - ez;
    mx = 0; my = 0; mz = 0;
    r.moved = !((dx == 0 && dy == 0 && dz == 0) || stp == 0);
    if (r.moved) begin
      if (dy == 0) begin
        if (dx == 0) mz = orient(stp, dz, stp);
        else begin
          mx = lead_dist(stp, dx, dz);
          mz = follow(dz, mx, dx);
        end
      end else if (dx == 0) begin
        if (dz == 0) my = orient(stp, dy, stp);
        else begin
          mz = lead_dist(stp, dz, dy);
          my = follow(dy, mz, dz);
        end
      end else begin
        mx = lead_dist(stp, dx, dy);
        my = follow(dy, mx, dx);
        mz = follow(dz, mx, dx);
      end
    end
    r.eye_x = clip32(ex + mx);
    r.eye_y = clip32(ey + my);
    r.eye_z = clip32(ez + mz);
    r.tgt_x = clip32(both ? tx + mx : tx);
    r.tgt_y = clip32(both ? ty + my : ty);
    r.tgt_z = clip32(both ? tz + mz : tz);
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = expected_moves.size();

  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      fail_count = 0;
      moved_count = 0;
      expected_moves.delete();
    end else begin
      if (in_valid && in_ready)
        expected_moves.push_back(predict_dolly(in_eye_x, in_eye_y, in_eye_z, in_target_x,
                                               in_target_y, in_target_z, in_step, in_move_both));
      if (out_valid && out_ready) begin
        if (expected_moves.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = expected_moves.pop_front();
          if (e.moved) moved_count++;
          check_field("new_eye_x", e.eye_x, out_new_eye_x);
          check_field("new_eye_y", e.eye_y, out_new_eye_y);
          check_field("new_eye_z", e.eye_z, out_new_eye_z);
          check_field("new_target_x", e.tgt_x, out_new_target_x);
          check_field("new_target_y", e.tgt_y, out_new_target_y);
          check_field("new_target_z", e.tgt_z, out_new_target_z);
          check_field("moved", e.moved, out_moved);
        end
      end
    end
  end
endmodule

// File: test/tb_view_point_dolly_step.sv
// ---------------------------------------------------------------------------
// tb_view_point_dolly_step
// Directed corner moves, then random eye/target/step requests under random
// gaps and result back-pressure; a checker module predicts and compares.
// ---------------------------------------------------------------------------
module tb_view_point_dolly_step;
  import vdolly_pkg::*;

  localparam int N_RANDOM   = 1630;
  localparam int LATENCY    = 109;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_AT    = 315;

  logic clk, rst_n;
  logic in_valid, in_ready, in_move_both;
  logic signed [COORD_W-1:0] in_eye_x, in_eye_y, in_eye_z;
  logic signed [COORD_W-1:0] in_target_x, in_target_y, in_target_z, in_step;
  logic out_valid, out_ready, out_moved;
  logic signed [COORD_W-1:0] out_new_eye_x, out_new_eye_y, out_new_eye_z;
  logic signed [COORD_W-1:0] out_new_target_x, out_new_target_y, out_new_target_z;
  int fail_count, pending, moved_count, sent, idle_cycles;

  view_point_dolly_step u_top (.*);

  vdolly_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom_range(0, 8191) - 4096;
      4: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // one request transfer; valid stays up until accepted and after it,
  // so back-to-back requests keep it high
  task automatic send_move(logic [31:0] ex, ey, ez, tx, ty, tz, stp, logic both);
    in_valid <= 1'b1;
    in_eye_x <= ex; in_eye_y <= ey; in_eye_z <= ez;
    in_target_x <= tx; in_target_y <= ty; in_target_z <= tz;
    in_step <= stp; in_move_both <= both;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
        ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic random_move();
    logic [31:0] ex, ey, ez, tx, ty, tz, stp;
    int shape;
    ex = pick_coord(); ey = pick_coord(); ez = pick_coord();
    tx = pick_coord(); ty = pick_coord(); tz = pick_coord();
    stp = pick_coord();
    shape = $urandom_range(0, 15);
    // steer some requests into the axis-aligned and degenerate branches
    if (shape == 0) ty = ey;
    if (shape == 1) begin ty = ey; tx = ex; end
    if (shape == 2) tx = ex;
    if (shape == 3) begin tx = ex; tz = ez; end
    if (shape == 4) stp = 0;
    if (shape == 5) begin tx = ex; ty = ey; tz = ez; end
    send_move(ex, ey, ez, tx, ty, tz, stp, 1'($urandom_range(0, 1)));
  endtask

  // result side: random stalls plus one long hold-off while requests keep coming
  initial begin
    int s;
    bit held;
    held = 0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && sent >= HOLD_AT) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      s = $urandom_range(0, 29);
      if (s == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 50)) @(posedge clk);
      end else begin
        out_ready <= (s > 8) || (s != 0 && $urandom_range(0, 1) != 0);
        @(posedge clk);
      end
    end
  end

  // watchdog on accepted transfers
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_valid = 0; in_move_both = 0; in_step = 0;
    in_eye_x = 0; in_eye_y = 0; in_eye_z = 0;
    in_target_x = 0; in_target_y = 0; in_target_z = 0;
    rst_n = 0; sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_move(0, 0, 0, 0, 0, 0, 32'h1000, 1);                 // zero delta
    send_move(0, 0, 0, 32'h1000, 32'h2000, 32'h3000, 0, 1);   // zero step
    send_move(0, 0, 0, 0, 0, 32'h5000, 32'h1000, 1);          // z only
    send_move(0, 0, 0, 0, 0, 32'h5000, 32'hfffff000, 0);
    send_move(0, 0, 0, 0, 32'h5000, 0, 32'h1000, 0);          // y only
    send_move(0, 0, 0, 0, 32'hffff0000, 0, 32'h7fffffff, 1);
    send_move(0, 0, 0, 32'h3000, 0, 32'h4000, 32'h1000, 1);   // x leads with z
    send_move(0, 0, 0, 0, 32'h3000, 32'h4000, 32'h1000, 1);   // z leads with y
    send_move(0, 0, 0, 32'h3000, 32'h4000, 32'h5000, 32'h1000, 1);
    send_move(32'h80000000, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
    send_move(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1);
    send_move(32'h7fffffff, 0, 0, 32'h80000000, 1, 32'h7fffffff, 32'h80000000, 0);
    send_move(0, 0, 0, 1, 32'h7fffffff, 32'h80000000, 1, 1);  // lead truncates to zero
    send_move(0, 0, 0, 32'h1000, 32'h1000, 0, 32'hffffffff, 1);
    send_move(32'h12345678, 32'hedcba987, 32'h0f0f0f0f,
              32'h12345679, 32'hedcba987, 32'h0f0f0f0f, 32'h80000000, 1);

    // sender pause until drained
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      random_move();
      if ($urandom_range(0, 3) != 0) random_gap();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("%0d requests sent, %0d of them moved the points", sent, moved_count);
    if (fail_count == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
